FILE: rtl/ecp_parallel_port_fifo_defines.svh
// ----------------------------------------------------------------------------
// ECP parallel port assertion macros
// Shared concurrent check templates for the port register block.
// ----------------------------------------------------------------------------
`ifndef ECP_PARALLEL_PORT_FIFO_DEFINES_SVH
`define ECP_PARALLEL_PORT_FIFO_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ECP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("ecp check failed: same-cycle rule");

// Next-cycle implication, checked outside reset
`define ECP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("ecp check failed: next-cycle rule");

`endif

FILE: rtl/ecp_pkg.sv
// ----------------------------------------------------------------------------
// ECP parallel port package
// Request and result types, register codes and the IRQ code table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecp_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_LINE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DMA_CHAN  = 2'd2;

    // Access kinds and register blocks
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;
    localparam logic BANK_SPP  = 1'b0;
    localparam logic BANK_ECP  = 1'b1;

    // Register offsets within a block
    localparam logic [1:0] OFF_DATA    = 2'd0;  // SPP data / ECP FIFO
    localparam logic [1:0] OFF_STATUS  = 2'd1;  // SPP status / ECP config B
    localparam logic [1:0] OFF_CONTROL = 2'd2;  // SPP control / ECP ECR

    // Effective port modes
    localparam logic [2:0] MODE_SPP    = 3'd0;
    localparam logic [2:0] MODE_PS2    = 3'd1;
    localparam logic [2:0] MODE_FIFO   = 3'd2;
    localparam logic [2:0] MODE_ECP    = 3'd3;
    localparam logic [2:0] MODE_TEST   = 3'd6;
    localparam logic [2:0] MODE_CONFIG = 3'd7;
    localparam logic [2:0] SPP_SEL_COMPAT = 3'd4;

    // Fixed read values and masks
    localparam logic [7:0] STATUS_IDLE   = 8'h78;
    localparam logic [7:0] CNFGA_VALUE   = 8'h10;
    localparam logic [7:0] READ_NONE     = 8'hff;
    localparam logic [7:0] CTRL_WR_MASK  = 8'h3f;
    localparam logic [7:0] ECR_WR_MASK   = 8'hfc;
    localparam logic [3:0] THR_BASE      = 4'd15;

    typedef struct packed {
        logic [7:0] write_data;
        logic [1:0] offset;
        logic       bank;
        logic       cmd;
    } t_item;

    typedef struct packed {
        logic       irq_request;
        logic [7:0] read_data;
    } t_result;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } t_cfg_wr;

    // Map an interrupt line to its configuration B code
    function automatic logic [2:0] irq_code(input logic [3:0] line);
        logic [2:0] code;
        case (line)
            4'd5:    code = 3'd7;
            4'd7:    code = 3'd1;
            4'd9:    code = 3'd2;
            4'd10:   code = 3'd3;
            4'd11:   code = 3'd4;
            4'd14:   code = 3'd5;
            4'd15:   code = 3'd6;
            default: code = 3'd0;
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/ecp_in_stage.sv
// ----------------------------------------------------------------------------
// ECP input register
// Holds one accepted bus request until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecp_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ecp_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output ecp_pkg::t_item o_item
);

    logic           r_valid;
    ecp_pkg::t_item r_item;

    // Accept whenever the slot is empty or draining this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_valid && o_ready) || (r_valid && !i_advance);
        end
    end

    // Capture payload on accept
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/ecp_core.sv
// ----------------------------------------------------------------------------
// ECP register core
// Register file, FIFO and service logic; one request updated per cycle when advanced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ecp_parallel_port_fifo_defines.svh"

module ecp_core #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  ecp_pkg::t_item   i_item,
    input  ecp_pkg::t_cfg_wr i_cfg,
    output ecp_pkg::t_result o_result
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Configuration
    logic [7:0]       r_port_mode, n_port_mode;
    logic [3:0]       r_irq_line, n_irq_line;
    logic [2:0]       r_dma, n_dma;
    // Port state
    logic [7:0]       r_data_latch, n_data_latch;
    logic [5:0]       r_control, n_control;
    logic [7:0]       r_ecr, n_ecr;
    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_last, n_last;
    logic             r_service, n_service;
    logic [7:0]       r_store [DEPTH];
    logic [7:0]       r_head_byte;

    logic             w_we;
    logic [PTR_W-1:0] w_tail;
    logic [7:0]       w_rd;
    logic             w_ecr_clear;

    // Effective mode from ECR or from the SPP mode field
    function automatic logic [2:0] eff_mode(input logic [7:0] cfg, input logic [7:0] ecr);
        logic [2:0] m;
        if (cfg[1]) begin
            m = ecr[7:5];
        end else begin
            m = (cfg[2:0] == ecp_pkg::SPP_SEL_COMPAT) ? ecp_pkg::MODE_SPP : ecp_pkg::MODE_PS2;
        end
        return m;
    endfunction

    // Service condition: enough free (forward) or filled (reverse) space
    function automatic logic service_hit(input logic [7:0] cfg, input logic [7:0] ecr,
                                         input logic [5:0] ctrl, input logic [CNT_W-1:0] cnt);
        logic [2:0]       m;
        logic [3:0]       thr;
        logic             rev;
        logic [CNT_W-1:0] avail;
        m     = eff_mode(cfg, ecr);
        thr   = (cfg[6:3] == ecp_pkg::THR_BASE) ? 4'd1 : (ecp_pkg::THR_BASE - cfg[6:3]);
        rev   = (m != ecp_pkg::MODE_FIFO) && ctrl[5];
        avail = rev ? cnt : (CNT_W'(DEPTH) - cnt);
        return (m inside {ecp_pkg::MODE_FIFO, ecp_pkg::MODE_ECP, ecp_pkg::MODE_TEST}) &&
               (ecr[3:2] == 2'b00) && (avail >= CNT_W'(thr));
    endfunction

    assign w_tail = r_head + r_count[PTR_W-1:0];

    // Decode the request and work out the next state
    always_comb begin
        logic [2:0] mode;
        logic       rev;
        logic       push;
        logic       pop;
        logic       check;
        n_port_mode  = r_port_mode;
        n_irq_line   = r_irq_line;
        n_dma        = r_dma;
        n_data_latch = r_data_latch;
        n_control    = r_control;
        n_ecr        = r_ecr;
        n_head       = r_head;
        n_count      = r_count;
        n_last       = r_last;
        n_service    = r_service;
        w_we         = 1'b0;
        w_rd         = ecp_pkg::READ_NONE;
        mode         = eff_mode(r_port_mode, r_ecr);
        rev          = r_control[5];
        push         = 1'b0;
        pop          = 1'b0;
        check        = 1'b0;

        if (i_cfg.valid) begin
            case (i_cfg.index)
                ecp_pkg::CFG_PORT_MODE: begin
                    n_port_mode = i_cfg.data;
                    check       = 1'b1;
                end
                ecp_pkg::CFG_IRQ_LINE: begin
                    n_irq_line = i_cfg.data[3:0];
                    check      = 1'b1;
                end
                ecp_pkg::CFG_DMA_CHAN: begin
                    n_dma = i_cfg.data[2:0];
                    check = 1'b1;
                end
                default: ;
            endcase
        end else if (i_advance) begin
            if (i_item.bank == ecp_pkg::BANK_SPP) begin
                if (i_item.cmd == ecp_pkg::CMD_WRITE) begin
                    case (i_item.offset)
                        ecp_pkg::OFF_DATA: begin
                            if (mode == ecp_pkg::MODE_ECP && !rev) begin
                                push = 1'b1;
                            end else begin
                                n_data_latch = i_item.write_data;
                            end
                        end
                        ecp_pkg::OFF_CONTROL: begin
                            n_control = i_item.write_data[5:0] & ecp_pkg::CTRL_WR_MASK[5:0];
                            check     = 1'b1;
                        end
                        default: ;
                    endcase
                end else begin
                    case (i_item.offset)
                        ecp_pkg::OFF_DATA: begin
                            if (mode == ecp_pkg::MODE_SPP || !rev) begin
                                w_rd = r_data_latch;
                            end
                        end
                        ecp_pkg::OFF_STATUS:  w_rd = ecp_pkg::STATUS_IDLE;
                        ecp_pkg::OFF_CONTROL: w_rd = {2'b00, r_control};
                        default: ;
                    endcase
                end
            end else if (r_port_mode[1] && (i_item.offset inside
                         {ecp_pkg::OFF_DATA, ecp_pkg::OFF_STATUS, ecp_pkg::OFF_CONTROL})) begin
                if (i_item.cmd == ecp_pkg::CMD_WRITE) begin
                    if (i_item.offset == ecp_pkg::OFF_CONTROL) begin
                        // ECR write: clear service, flush in the plain modes
                        n_ecr     = i_item.write_data & ecp_pkg::ECR_WR_MASK;
                        n_service = 1'b0;
                        if (i_item.write_data[7:5] <= ecp_pkg::MODE_PS2) begin
                            n_head  = '0;
                            n_count = '0;
                        end
                        check = 1'b1;
                    end else if (i_item.offset == ecp_pkg::OFF_DATA &&
                                 (mode == ecp_pkg::MODE_FIFO || mode == ecp_pkg::MODE_TEST ||
                                  (mode == ecp_pkg::MODE_ECP && !rev))) begin
                        push = 1'b1;
                    end
                end else begin
                    if (i_item.offset == ecp_pkg::OFF_CONTROL) begin
                        w_rd = r_ecr | {6'b0, (r_count == CNT_W'(DEPTH)), (r_count == '0)};
                    end else if (mode == ecp_pkg::MODE_CONFIG) begin
                        if (i_item.offset == ecp_pkg::OFF_DATA) begin
                            w_rd = ecp_pkg::CNFGA_VALUE;
                        end else begin
                            w_rd = {1'b0, r_service, ecp_pkg::irq_code(r_irq_line),
                                    (r_dma[2] ? 3'd0 : r_dma)};
                        end
                    end else if (i_item.offset == ecp_pkg::OFF_DATA &&
                                 (mode == ecp_pkg::MODE_TEST ||
                                  (mode == ecp_pkg::MODE_ECP && rev))) begin
                        pop = 1'b1;
                    end
                end
            end
        end

        // Push drops the byte when full; pop of an empty FIFO repeats the last byte
        if (push) begin
            if (r_count < CNT_W'(DEPTH)) begin
                w_we    = 1'b1;
                n_count = r_count + 1'b1;
            end
            check = 1'b1;
        end
        if (pop) begin
            if (r_count != '0) begin
                n_last  = r_head_byte;
                n_head  = r_head + 1'b1;
                n_count = r_count - 1'b1;
            end
            w_rd  = n_last;
            check = 1'b1;
        end

        // Re-evaluate the service request on the updated state
        if (check && service_hit(n_port_mode, n_ecr, n_control, n_count)) begin
            n_ecr[2]  = 1'b1;
            n_service = 1'b1;
        end
    end

    assign o_result.read_data   = (i_item.cmd == ecp_pkg::CMD_WRITE) ? ecp_pkg::READ_NONE : w_rd;
    assign o_result.irq_request = n_service;

    // Hold control and register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_mode  <= '0;
            r_irq_line   <= '0;
            r_dma        <= '0;
            r_data_latch <= '0;
            r_control    <= '0;
            r_ecr        <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_last       <= '0;
            r_service    <= 1'b0;
        end else begin
            r_port_mode  <= n_port_mode;
            r_irq_line   <= n_irq_line;
            r_dma        <= n_dma;
            r_data_latch <= n_data_latch;
            r_control    <= n_control;
            r_ecr        <= n_ecr;
            r_head       <= n_head;
            r_count      <= n_count;
            r_last       <= n_last;
            r_service    <= n_service;
        end
    end

    // FIFO storage, written at the tail; keep the byte at the next head ready
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_tail] <= i_item.write_data;
        end
        if (w_we && w_tail == n_head) begin
            r_head_byte <= i_item.write_data;
        end else begin
            r_head_byte <= r_store[n_head];
        end
    end

    assign w_ecr_clear = i_advance && !i_cfg.valid && i_item.bank == ecp_pkg::BANK_ECP &&
                         i_item.cmd == ecp_pkg::CMD_WRITE &&
                         i_item.offset == ecp_pkg::OFF_CONTROL && r_port_mode[1] &&
                         i_item.write_data[7:5] <= ecp_pkg::MODE_PS2;

    `ECP_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))
    `ECP_ASSERT_IMPL(a_irq_has_ecr_flag, r_service, r_ecr[2])
    `ECP_ASSERT_IMPL(a_ecr_low_clear, 1'b1, r_ecr[1:0] == 2'b00)
    `ECP_ASSERT_NEXT(a_ecr_flush, w_ecr_clear, r_count == '0 && r_head == '0)

endmodule

FILE: rtl/ecp_out_stage.sv
// ----------------------------------------------------------------------------
// ECP result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ecp_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output ecp_pkg::t_result o_result
);

    logic             r_valid;
    ecp_pkg::t_result r_result;

    // Free when empty or being taken this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: rtl/ecp_parallel_port_fifo.sv
// ----------------------------------------------------------------------------
// ECP parallel port register block
// SPP and ECP registers with a byte FIFO, one bus request per cycle while results are taken.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser: cmd, bank, offset
//                                                      tdata: write_data
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: read_data, irq_request
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  One request per cycle sustained while results are taken; an accepted request goes
//  through the input register, then one state update into the result register.
//  The register and FIFO state updates once per request, so requests follow back to back.
//  Synchronous active-low reset clears the valid flags, the control and configuration
//  registers, the FIFO pointers and count. A stalled result holds the input register;
//  configuration writes wait for it to be empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecp_parallel_port_fifo #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] write_data
    input  logic [3:0]  s_axis_tuser,   // [0] cmd, [1] bank, [3:2] offset
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] read_data, [8] irq_request, [15:9] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ecp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    ecp_pkg::t_item   w_in_item;
    ecp_pkg::t_item   w_item;
    ecp_pkg::t_result w_result;
    ecp_pkg::t_result w_out_result;
    ecp_pkg::t_cfg_wr w_cfg;
    logic             w_in_valid;
    logic             w_out_free;
    logic             w_advance;

    // Unpack the request
    assign w_in_item.cmd        = s_axis_tuser[0];
    assign w_in_item.bank       = s_axis_tuser[1];
    assign w_in_item.offset     = s_axis_tuser[3:2];
    assign w_in_item.write_data = s_axis_tdata;

    // Move a request into the core when the result slot can take it
    assign w_advance = w_in_valid && w_out_free;

    // Configuration writes only while no request is waiting
    assign o_cfg_ready = !w_in_valid;
    assign w_cfg.valid = i_cfg_valid && o_cfg_ready;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    ecp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    ecp_core #(
        .DEPTH (FIFO_DEPTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_item),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    ecp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out_result)
    );

    // Pack the result
    assign m_axis_tdata = {7'b0, w_out_result.irq_request, w_out_result.read_data};

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// ECP parallel port register block testbench
// Drives SPP and ECP register requests through the stream input, predicts the
// read data and the service interrupt level of each request, and compares
// every result in order. A short directed table runs first, then randomized
// bursts of FIFO pushes, pops, mode changes and register reads, across several
// port configurations, with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int DEPTH        = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_PHASES     = 7;
    localparam logic [1:0] OFF_SPARE = 2'd3;
    localparam int DIR_BIT = 5;
    localparam int SVC_BIT = 2;
    localparam int DMA_BIT = 3;

    typedef enum int {
        BK_PUSH, BK_POP, BK_ECR_WR, BK_CTRL_WR, BK_REG_RD, BK_SPP, BK_NOISE
    } t_burst;

    typedef struct {
        bit                            is_cfg;
        logic [ecp_pkg::CFG_IDX_W-1:0] cfg_idx;
        logic [7:0]                    cfg_data;
        ecp_pkg::t_item                acc;
        bit                            typed;
        ecp_pkg::t_result              res;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata;   // [7:0] write_data
    logic [3:0]                    s_axis_tuser;   // [0] cmd, [1] bank, [3:2] offset
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [15:0]                   m_axis_tdata;   // [7:0] read_data, [8] irq_request
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [ecp_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]                    i_cfg_data;

    // Predicted port state
    bit [7:0] pm_cfg;
    bit [3:0] irq_cfg;
    bit [2:0] dma_cfg;
    bit [7:0] latch_q;
    bit [5:0] ctrl_q;
    bit [7:0] ecr_q;
    bit [7:0] fifo_mem [DEPTH];
    bit [3:0] head_q;
    bit [4:0] count_q;
    bit [7:0] popped_q;
    bit       svc_q;

    ecp_pkg::t_result exp_port_results [$];
    t_dir_row         dir_table [$];
    t_burst           burst_kind;
    int               burst_left = 0;
    int unsigned      item_no = 0;
    bit               no_idle = 1'b0;
    int               mismatch_count = 0;

    ecp_parallel_port_fifo #(
        .FIFO_DEPTH(DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Mode in effect: ECR field when ECP is on, else compatibility or PS/2
    function automatic bit [2:0] cur_mode();
        if (pm_cfg[1])
            return ecr_q[7:5];
        return (pm_cfg[2:0] == ecp_pkg::SPP_SEL_COMPAT) ? ecp_pkg::MODE_SPP : ecp_pkg::MODE_PS2;
    endfunction

    function automatic bit [2:0] cfgb_irq_code(input bit [3:0] line);
        bit [2:0] code;
        case (line)
            4'd5:    code = 3'd7;
            4'd7:    code = 3'd1;
            4'd9:    code = 3'd2;
            4'd10:   code = 3'd3;
            4'd11:   code = 3'd4;
            4'd14:   code = 3'd5;
            4'd15:   code = 3'd6;
            default: code = 3'd0;
        endcase
        return code;
    endfunction

    // Raise the service request once enough space is free (or filled in reverse)
    function automatic void rescan_service();
        bit [2:0] mode;
        int       thr;
        int       avail;
        bit       rev;
        mode = cur_mode();
        thr = int'(ecp_pkg::THR_BASE) - int'(pm_cfg[6:3]);
        if (thr < 1)
            thr = 1;
        rev = (mode != ecp_pkg::MODE_FIFO) && ctrl_q[DIR_BIT];
        avail = rev ? int'(count_q) : DEPTH - int'(count_q);
        if ((mode == ecp_pkg::MODE_FIFO || mode == ecp_pkg::MODE_ECP ||
             mode == ecp_pkg::MODE_TEST) &&
            !ecr_q[SVC_BIT] && !ecr_q[DMA_BIT] && avail >= thr) begin
            ecr_q[SVC_BIT] = 1'b1;
            svc_q = 1'b1;
        end
    endfunction

    // Append a byte, drop it when full
    function automatic void fifo_in(input bit [7:0] v);
        bit [3:0] slot;
        if (count_q < DEPTH) begin
            slot = head_q + count_q[3:0];
            fifo_mem[slot] = v;
            count_q++;
        end
        rescan_service();
    endfunction

    // Take the oldest byte; an empty FIFO repeats the last one
    function automatic bit [7:0] fifo_out();
        if (count_q != 0) begin
            popped_q = fifo_mem[head_q];
            head_q++;
            count_q--;
        end
        rescan_service();
        return popped_q;
    endfunction

    // Update the predicted state for one request and return its result
    function automatic ecp_pkg::t_result port_access_result(input ecp_pkg::t_item acc);
        bit [2:0]         mode;
        bit               rev;
        bit [7:0]         rd;
        bit [7:0]         wd;
        ecp_pkg::t_result res;
        mode = cur_mode();
        rev = ctrl_q[DIR_BIT];
        rd = ecp_pkg::READ_NONE;
        wd = acc.write_data;
        if (acc.bank == ecp_pkg::BANK_SPP) begin
            if (acc.cmd == ecp_pkg::CMD_WRITE) begin
                if (acc.offset == ecp_pkg::OFF_DATA) begin
                    if (mode == ecp_pkg::MODE_ECP && !rev)
                        fifo_in(wd);
                    else
                        latch_q = wd;
                end else if (acc.offset == ecp_pkg::OFF_CONTROL) begin
                    wd = wd & ecp_pkg::CTRL_WR_MASK;
                    ctrl_q = wd[5:0];
                    rescan_service();
                end
            end else begin
                case (acc.offset)
                    ecp_pkg::OFF_DATA: begin
                        if (mode == ecp_pkg::MODE_SPP || !rev)
                            rd = latch_q;
                    end
                    ecp_pkg::OFF_STATUS:  rd = ecp_pkg::STATUS_IDLE;
                    ecp_pkg::OFF_CONTROL: rd = {2'b00, ctrl_q};
                    default:              rd = ecp_pkg::READ_NONE;
                endcase
            end
        end else if (pm_cfg[1] && acc.offset != OFF_SPARE) begin
            if (acc.cmd == ecp_pkg::CMD_WRITE) begin
                if (acc.offset == ecp_pkg::OFF_CONTROL) begin
                    ecr_q = wd & ecp_pkg::ECR_WR_MASK;
                    svc_q = 1'b0;
                    if (ecr_q[7:5] <= ecp_pkg::MODE_PS2) begin
                        head_q = '0;
                        count_q = '0;
                    end
                    rescan_service();
                end else if (acc.offset == ecp_pkg::OFF_DATA &&
                             (mode == ecp_pkg::MODE_FIFO || mode == ecp_pkg::MODE_TEST ||
                              (mode == ecp_pkg::MODE_ECP && !rev))) begin
                    fifo_in(wd);
                end
            end else begin
                if (acc.offset == ecp_pkg::OFF_CONTROL) begin
                    rd = ecr_q | {6'b0, count_q == 5'(DEPTH), count_q == 5'd0};
                end else if (mode == ecp_pkg::MODE_CONFIG) begin
                    if (acc.offset == ecp_pkg::OFF_DATA)
                        rd = ecp_pkg::CNFGA_VALUE;
                    else
                        rd = {1'b0, svc_q, cfgb_irq_code(irq_cfg),
                              (dma_cfg < 3'd4) ? dma_cfg : 3'd0};
                end else if (acc.offset == ecp_pkg::OFF_DATA &&
                             (mode == ecp_pkg::MODE_TEST ||
                              (mode == ecp_pkg::MODE_ECP && rev))) begin
                    rd = fifo_out();
                end
            end
        end
        res.read_data = (acc.cmd == ecp_pkg::CMD_WRITE) ? ecp_pkg::READ_NONE : rd;
        res.irq_request = svc_q;
        return res;
    endfunction

    function automatic void add_access(input logic cmd, input logic bank,
                                       input logic [1:0] off, input logic [7:0] wd,
                                       input bit typed, input logic [7:0] rd,
                                       input logic irq);
        t_dir_row row;
        row.is_cfg = 1'b0;
        row.cfg_idx = '0;
        row.cfg_data = '0;
        row.acc.cmd = cmd;
        row.acc.bank = bank;
        row.acc.offset = off;
        row.acc.write_data = wd;
        row.typed = typed;
        row.res.read_data = rd;
        row.res.irq_request = irq;
        dir_table.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [ecp_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [7:0] data);
        t_dir_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_idx = idx;
        row.cfg_data = data;
        dir_table.push_back(row);
    endfunction

    // Random request, grouped into bursts of one kind so the FIFO fills and drains
    function automatic ecp_pkg::t_item next_access();
        ecp_pkg::t_item acc;
        int             pick;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                burst_kind = BK_PUSH;
                burst_left = $urandom_range(1, 20);
            end else if (pick < 48) begin
                burst_kind = BK_POP;
                burst_left = $urandom_range(1, 20);
            end else if (pick < 58) begin
                burst_kind = BK_ECR_WR;
                burst_left = 1;
            end else if (pick < 66) begin
                burst_kind = BK_CTRL_WR;
                burst_left = 1;
            end else if (pick < 78) begin
                burst_kind = BK_REG_RD;
                burst_left = $urandom_range(1, 3);
            end else if (pick < 90) begin
                burst_kind = BK_SPP;
                burst_left = $urandom_range(1, 4);
            end else begin
                burst_kind = BK_NOISE;
                burst_left = $urandom_range(1, 4);
            end
        end
        burst_left--;
        acc.cmd = 1'($urandom_range(0, 1));
        acc.bank = 1'($urandom_range(0, 1));
        acc.offset = 2'($urandom_range(0, 3));
        acc.write_data = 8'($urandom_range(0, 255));
        case (burst_kind)
            BK_PUSH: begin
                acc.cmd = ecp_pkg::CMD_WRITE;
                acc.bank = ecp_pkg::BANK_ECP;
                acc.offset = ecp_pkg::OFF_DATA;
            end
            BK_POP: begin
                acc.cmd = ecp_pkg::CMD_READ;
                acc.bank = ecp_pkg::BANK_ECP;
                acc.offset = ecp_pkg::OFF_DATA;
            end
            BK_ECR_WR: begin
                acc.cmd = ecp_pkg::CMD_WRITE;
                acc.bank = ecp_pkg::BANK_ECP;
                acc.offset = ecp_pkg::OFF_CONTROL;
                // Favor the FIFO modes and keep service armed most of the time
                if ($urandom_range(0, 9) < 7) begin
                    case ($urandom_range(0, 2))
                        0:       acc.write_data[7:5] = ecp_pkg::MODE_FIFO;
                        1:       acc.write_data[7:5] = ecp_pkg::MODE_ECP;
                        default: acc.write_data[7:5] = ecp_pkg::MODE_TEST;
                    endcase
                end
                if ($urandom_range(0, 3) != 0)
                    acc.write_data[3:2] = 2'b00;
            end
            BK_CTRL_WR: begin
                acc.cmd = ecp_pkg::CMD_WRITE;
                acc.bank = ecp_pkg::BANK_SPP;
                acc.offset = ecp_pkg::OFF_CONTROL;
            end
            BK_REG_RD: begin
                acc.cmd = ecp_pkg::CMD_READ;
                acc.bank = ecp_pkg::BANK_ECP;
            end
            BK_SPP: acc.bank = ecp_pkg::BANK_SPP;
            default: ;
        endcase
        return acc;
    endfunction

    // Send one request after a random gap and record its expected result
    task automatic send_access(input ecp_pkg::t_item acc, input bit typed,
                               input ecp_pkg::t_result typed_res);
        int               gap;
        ecp_pkg::t_result predicted;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= acc.write_data;
        s_axis_tuser <= {acc.offset, acc.bank, acc.cmd};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predicted = port_access_result(acc);
        exp_port_results.push_back(typed ? typed_res : predicted);
        item_no++;
        no_idle = ((item_no / 128) % 4) == 3;
    endtask

    // Stop requests and wait for every outstanding result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (exp_port_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [ecp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            ecp_pkg::CFG_PORT_MODE: pm_cfg = data;
            ecp_pkg::CFG_IRQ_LINE:  irq_cfg = data[3:0];
            ecp_pkg::CFG_DMA_CHAN:  dma_cfg = data[2:0];
            default: ;
        endcase
        rescan_service();
    endtask

    // Stimulus: directed table, then randomized phases
    initial begin
        logic [7:0] pm;
        logic [3:0] irq;
        logic [2:0] dma;
        int         n_items;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;

        // Reset values, fixed reads, unmapped and undecoded registers
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_SPP, ecp_pkg::OFF_DATA, 8'h00,
                   1, 8'h00, 1'b0);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_SPP, ecp_pkg::OFF_STATUS, 8'h00,
                   1, ecp_pkg::STATUS_IDLE, 1'b0);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_SPP, ecp_pkg::OFF_CONTROL, 8'h00,
                   1, 8'h00, 1'b0);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_SPP, OFF_SPARE, 8'h00,
                   1, ecp_pkg::READ_NONE, 1'b0);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_ECP, ecp_pkg::OFF_DATA, 8'h00,
                   1, ecp_pkg::READ_NONE, 1'b0);
        add_access(ecp_pkg::CMD_WRITE, ecp_pkg::BANK_ECP, ecp_pkg::OFF_CONTROL, 8'hff,
                   1, ecp_pkg::READ_NONE, 1'b0);
        // Data latch, control mask, reverse data read
        add_access(ecp_pkg::CMD_WRITE, ecp_pkg::BANK_SPP, ecp_pkg::OFF_DATA, 8'h5a,
                   1, ecp_pkg::READ_NONE, 1'b0);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_SPP, ecp_pkg::OFF_DATA, 8'h00,
                   1, 8'h5a, 1'b0);
        add_access(ecp_pkg::CMD_WRITE, ecp_pkg::BANK_SPP, ecp_pkg::OFF_CONTROL, 8'hff,
                   1, ecp_pkg::READ_NONE, 1'b0);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_SPP, ecp_pkg::OFF_CONTROL, 8'h00,
                   1, 8'h3f, 1'b0);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_SPP, ecp_pkg::OFF_DATA, 8'h00,
                   1, ecp_pkg::READ_NONE, 1'b0);
        add_access(ecp_pkg::CMD_WRITE, ecp_pkg::BANK_SPP, ecp_pkg::OFF_CONTROL, 8'h00,
                   1, ecp_pkg::READ_NONE, 1'b0);
        // ECP on, lowest threshold
        add_cfg(ecp_pkg::CFG_PORT_MODE, 8'hff);
        add_cfg(ecp_pkg::CFG_IRQ_LINE, 8'h05);
        add_cfg(ecp_pkg::CFG_DMA_CHAN, 8'h03);
        add_access(ecp_pkg::CMD_WRITE, ecp_pkg::BANK_ECP, ecp_pkg::OFF_CONTROL, 8'h40,
                   1, ecp_pkg::READ_NONE, 1'b1);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_ECP, ecp_pkg::OFF_CONTROL, 8'h00,
                   1, 8'h45, 1'b1);
        add_access(ecp_pkg::CMD_WRITE, ecp_pkg::BANK_ECP, ecp_pkg::OFF_DATA, 8'h00,
                   0, 8'h00, 1'b0);
        add_access(ecp_pkg::CMD_WRITE, ecp_pkg::BANK_ECP, ecp_pkg::OFF_DATA, 8'hff,
                   0, 8'h00, 1'b0);
        // Configuration mode reads
        add_access(ecp_pkg::CMD_WRITE, ecp_pkg::BANK_ECP, ecp_pkg::OFF_CONTROL, 8'he0,
                   1, ecp_pkg::READ_NONE, 1'b0);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_ECP, ecp_pkg::OFF_DATA, 8'h00,
                   1, ecp_pkg::CNFGA_VALUE, 1'b0);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_ECP, ecp_pkg::OFF_STATUS, 8'h00,
                   1, 8'h3b, 1'b0);
        // Test mode pops, down to an empty FIFO
        add_access(ecp_pkg::CMD_WRITE, ecp_pkg::BANK_ECP, ecp_pkg::OFF_CONTROL, 8'hc0,
                   0, 8'h00, 1'b0);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_ECP, ecp_pkg::OFF_DATA, 8'h00,
                   0, 8'h00, 1'b0);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_ECP, ecp_pkg::OFF_DATA, 8'h00,
                   0, 8'h00, 1'b0);
        add_access(ecp_pkg::CMD_READ, ecp_pkg::BANK_ECP, ecp_pkg::OFF_DATA, 8'h00,
                   0, 8'h00, 1'b0);
        add_access(ecp_pkg::CMD_WRITE, ecp_pkg::BANK_ECP, OFF_SPARE, 8'hff,
                   0, 8'h00, 1'b0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[r]) begin
            if (dir_table[r].is_cfg) begin
                drain_results();
                write_cfg(dir_table[r].cfg_idx, dir_table[r].cfg_data);
            end else begin
                send_access(dir_table[r].acc, dir_table[r].typed, dir_table[r].res);
            end
        end

        // Random phases over a range of port settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            n_items = 300;
            case (ph)
                0: begin pm = 8'h02; irq = 4'd5;  dma = 3'd3; end
                1: begin pm = 8'hff; irq = 4'd15; dma = 3'd7; end
                2: begin pm = 8'h00; irq = 4'd0;  dma = 3'd0; n_items = 120; end
                3: begin pm = 8'h7c; irq = 4'd7;  dma = 3'd4; n_items = 120; end
                4: begin pm = 8'h3a; irq = 4'd10; dma = 3'd2; end
                5: begin pm = 8'h42; irq = 4'd11; dma = 3'd1; end
                default: begin
                    pm = {6'($urandom_range(0, 63)), 2'b10};
                    irq = 4'($urandom_range(0, 15));
                    dma = 3'($urandom_range(0, 7));
                end
            endcase
            drain_results();
            write_cfg(ecp_pkg::CFG_PORT_MODE, pm);
            write_cfg(ecp_pkg::CFG_IRQ_LINE, {4'($urandom_range(0, 15)), irq});
            write_cfg(ecp_pkg::CFG_DMA_CHAN, {5'($urandom_range(0, 31)), dma});
            repeat (n_items)
                send_access(next_access(), 1'b0, '0);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("ecp_parallel_port_fifo test passed");
        else
            $display("ecp_parallel_port_fifo test failed");
        $finish;
    end

    // Result side: random stall before each result
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        ecp_pkg::t_result want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (exp_port_results.size() == 0) begin
                $display("%0t: result %04h with none expected", $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = exp_port_results.pop_front();
                if (m_axis_tdata[7:0] !== want.read_data) begin
                    $display("%0t: read_data expected %02h actual %02h",
                             $time, want.read_data, m_axis_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[8] !== want.irq_request) begin
                    $display("%0t: irq_request expected %0b actual %0b",
                             $time, want.irq_request, m_axis_tdata[8]);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when no request moves for too long
    initial begin
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ecp_parallel_port_fifo test failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ecp_pkg.sv
rtl/ecp_in_stage.sv
rtl/ecp_core.sv
rtl/ecp_out_stage.sv
rtl/ecp_parallel_port_fifo.sv
sim/tb_top.sv
